>>> hdl/lph_pkg.sv
// Shared types and constants for the linear-probing hash set.
// No dependencies; imported by every module of the block.
package lph_pkg;

   localparam int DEFAULT_SLOTS = 256;
   localparam int KEY_W = 32;
   localparam int HASH_W = 32;
   localparam int OPS_W = 32;
   localparam int SUM_W = 48;
   // hash bits folded into the remainder per cycle when SLOTS is not a power of two
   localparam int RED_BITS = 4;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_IGNORE = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EXISTS = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      TAG_EMPTY = 2'd0,
      TAG_LIVE = 2'd1,
      TAG_TOMB = 2'd2
   } tag_type;

   typedef struct packed {
      tag_type tag;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic count_en;
      logic inc;
      logic dec;
   } stat_upd_type;

endpackage

>>> hdl/lph_mod_reduce.sv
// Reduces the incoming hash modulo SLOTS.
// Depends on lph_pkg. Mask when SLOTS is a power of two, else shift-subtract.
module lph_mod_reduce import lph_pkg::*; #(
   parameter int SLOTS = DEFAULT_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [HASH_W-1:0]          hash_value,
   output logic                       done,
   output logic [$clog2(SLOTS)-1:0]   result
);

   localparam int IDX_W = $clog2(SLOTS);

   generate
      if ((1 << IDX_W) == SLOTS) begin : g_mask
         logic done_ff;
         logic [IDX_W-1:0] res_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               res_ff <= hash_value[IDX_W-1:0];
            end
         end

         assign done = done_ff;
         assign result = res_ff;
      end else begin : g_iter
         localparam int STEPS = HASH_W / RED_BITS;
         localparam int CNT_W = $clog2(STEPS);

         logic run_ff;
         logic done_ff;
         logic [CNT_W-1:0] cnt_ff;
         logic [HASH_W-1:0] sh_ff;
         logic [IDX_W-1:0] r_ff;
         logic [IDX_W-1:0] r_in;

         // fold RED_BITS hash bits into the running remainder
         always_comb begin
            logic [IDX_W:0] t;
            logic [IDX_W-1:0] r;
            r = r_ff;
            for (int i = 0; i < RED_BITS; i++) begin
               t = {r, sh_ff[HASH_W-1-i]};
               if (t >= (IDX_W+1)'(SLOTS)) begin
                  t = t - (IDX_W+1)'(SLOTS);
               end
               r = t[IDX_W-1:0];
            end
            r_in = r;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff <= 1'b0;
               done_ff <= 1'b0;
               cnt_ff <= '0;
            end else begin
               done_ff <= 1'b0;
               if (start) begin
                  run_ff <= 1'b1;
                  cnt_ff <= '0;
               end else if (run_ff) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == CNT_W'(STEPS-1)) begin
                     run_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
            if (start) begin
               sh_ff <= hash_value;
               r_ff <= '0;
            end else if (run_ff) begin
               sh_ff <= sh_ff << RED_BITS;
               r_ff <= r_in;
            end
         end

         assign done = done_ff;
         assign result = r_ff;
      end
   endgenerate

endmodule

>>> hdl/lph_table.sv
// Slot memory: tag and key per slot, one write and one registered read port.
// Depends on lph_pkg.
module lph_table import lph_pkg::*; #(
   parameter int SLOTS = DEFAULT_SLOTS
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(SLOTS)-1:0]   rd_addr,
   output entry_type                  rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(SLOTS)-1:0]   wr_addr,
   input  entry_type                  wr_data
);

   entry_type mem [SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lph_stats.sv
// Live count and running statistics: worst probe count, op count, probe sum.
// Depends on lph_pkg.
module lph_stats import lph_pkg::*; #(
   parameter int SLOTS = DEFAULT_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  stat_upd_type                upd,
   input  logic [$clog2(SLOTS+1)-1:0]  probes,
   output logic [$clog2(SLOTS+1)-1:0]  occupancy,
   output logic [$clog2(SLOTS+1)-1:0]  max_probes_seen,
   output logic [OPS_W-1:0]            operations_done,
   output logic [SUM_W-1:0]            probes_total
);

   localparam int CNT_W = $clog2(SLOTS+1);

   logic [CNT_W-1:0] live_ff, live_in;
   logic [CNT_W-1:0] worst_ff, worst_in;
   logic [OPS_W-1:0] ops_ff, ops_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W:0] sum_wide;

   always_comb begin
      live_in = live_ff;
      worst_in = worst_ff;
      ops_in = ops_ff;
      sum_in = sum_ff;
      sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(probes);
      if (upd.inc) begin
         live_in = live_ff + 1'b1;
      end else if (upd.dec && live_ff != '0) begin
         live_in = live_ff - 1'b1;
      end
      if (upd.count_en) begin
         if (probes > worst_ff) begin
            worst_in = probes;
         end
         if (ops_ff != '1) begin
            ops_in = ops_ff + 1'b1;
         end
         // saturate on carry out
         sum_in = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         worst_ff <= '0;
         ops_ff <= '0;
         sum_ff <= '0;
      end else begin
         live_ff <= live_in;
         worst_ff <= worst_in;
         ops_ff <= ops_in;
         sum_ff <= sum_in;
      end
   end

   assign occupancy = live_ff;
   assign max_probes_seen = worst_ff;
   assign operations_done = ops_ff;
   assign probes_total = sum_ff;

endmodule

>>> hdl/linear_probe_hash_set.sv
// Flow: an accepted op reduces its hash, then walks the slots from that index until the
// walk stops at a match or an empty slot or has read every slot, then finishes with the
// table write and the response beat. An ignored op or an add to a full table skips to finish.
// Throughput: one op at a time, busy until the response beat; one slot read per cycle.
// Reset: synchronous; a clearing pass over every slot empties the slot memory, busy high.
// Responses are one-cycle strobes; the receiver cannot stall.
module linear_probe_hash_set import lph_pkg::*; #(
   parameter int SLOTS = DEFAULT_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_operation,
   input  logic [KEY_W-1:0]            req_key_value,
   input  logic [HASH_W-1:0]           req_hash_value,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_found,
   output logic [$clog2(SLOTS+1)-1:0]  rsp_probes,
   output logic [$clog2(SLOTS+1)-1:0]  rsp_occupancy,
   output logic [$clog2(SLOTS+1)-1:0]  rsp_max_probes_seen,
   output logic [OPS_W-1:0]            rsp_operations_done,
   output logic [SUM_W-1:0]            rsp_probes_total
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS+1);

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_HASH   = 5'b00100,
      S_PROBE  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [IDX_W-1:0] clr_ff;
   logic [1:0] op_ff;
   logic [KEY_W-1:0] key_ff;
   logic skip_ff;
   logic [IDX_W-1:0] pos_ff, eval_pos_ff, hit_ff, tomb_ff;
   logic rvalid_ff;
   logic saw_tomb_ff;
   logic match_ff, empty_ff;
   logic [CNT_W-1:0] n_ff, count_ff;
   logic rsp_valid_ff;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0] rsp_probes_ff;

   logic accept;
   logic red_done;
   logic [IDX_W-1:0] red_result;
   logic [IDX_W-1:0] pos_next;
   logic hit_now, empty_now, last_now;

   logic rd_en;
   entry_type rd_data;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type wr_data;
   logic fin_wr;
   logic [IDX_W-1:0] fin_addr;
   entry_type fin_data;
   stat_upd_type upd;
   logic [CNT_W-1:0] occupancy;

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;

   lph_mod_reduce #(.SLOTS(SLOTS)) u_reduce (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .hash_value (req_hash_value),
      .done       (red_done),
      .result     (red_result)
   );

   lph_table #(.SLOTS(SLOTS)) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (pos_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   lph_stats #(.SLOTS(SLOTS)) u_stats (
      .clock           (clock),
      .reset           (reset),
      .upd             (upd),
      .probes          (count_ff),
      .occupancy       (occupancy),
      .max_probes_seen (rsp_max_probes_seen),
      .operations_done (rsp_operations_done),
      .probes_total    (rsp_probes_total)
   );

   assign pos_next = (pos_ff == IDX_W'(SLOTS-1)) ? '0 : pos_ff + 1'b1;
   assign rd_en = (state_ff == S_PROBE);

   // evaluation of the slot read in the previous cycle
   assign hit_now = (rd_data.tag == TAG_LIVE) && (rd_data.key == key_ff);
   assign empty_now = (rd_data.tag == TAG_EMPTY);
   assign last_now = (n_ff == CNT_W'(SLOTS-1));

   // finish: table write, counter update and response fields
   always_comb begin
      fin_wr = 1'b0;
      fin_addr = hit_ff;
      fin_data.tag = TAG_LIVE;
      fin_data.key = key_ff;
      upd = '0;
      rsp_status_in = ST_OK;
      rsp_found_in = 1'b0;
      if (skip_ff) begin
         rsp_status_in = (op_ff == OP_ADD) ? ST_OVERFLOW : ST_OK;
      end else begin
         upd.count_en = 1'b1;
         case (op_ff)
            OP_ADD: begin
               if (match_ff) begin
                  rsp_status_in = ST_EXISTS;
                  rsp_found_in = 1'b1;
               end else if (saw_tomb_ff || empty_ff) begin
                  fin_wr = 1'b1;
                  fin_addr = saw_tomb_ff ? tomb_ff : hit_ff;
                  upd.inc = 1'b1;
               end else begin
                  rsp_status_in = ST_OVERFLOW;
               end
            end
            OP_REMOVE: begin
               if (match_ff) begin
                  rsp_found_in = 1'b1;
                  fin_wr = 1'b1;
                  fin_data.tag = TAG_TOMB;
                  upd.dec = 1'b1;
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
            end
            OP_QUERY: begin
               if (match_ff) begin
                  rsp_found_in = 1'b1;
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
            end
            default: begin
               rsp_status_in = ST_OK;
            end
         endcase
      end
      if (state_ff != S_FINISH) begin
         fin_wr = 1'b0;
         upd = '0;
      end
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_ff;
         wr_data.tag = TAG_EMPTY;
         wr_data.key = '0;
      end else begin
         wr_en = fin_wr;
         wr_addr = fin_addr;
         wr_data = fin_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == IDX_W'(SLOTS-1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_IGNORE ||
                   (req_operation == OP_ADD && occupancy == CNT_W'(SLOTS))) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (red_done) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (rvalid_ff && (hit_now || empty_now || last_now)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         rsp_valid_ff <= (state_ff == S_FINISH);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_operation;
         key_ff <= req_key_value;
         skip_ff <= (req_operation == OP_IGNORE) ||
                    (req_operation == OP_ADD && occupancy == CNT_W'(SLOTS));
         count_ff <= '0;
      end
      if (state_ff == S_HASH) begin
         pos_ff <= red_result;
         rvalid_ff <= 1'b0;
         n_ff <= '0;
         saw_tomb_ff <= 1'b0;
         match_ff <= 1'b0;
         empty_ff <= 1'b0;
      end
      if (state_ff == S_PROBE) begin
         // reads run one slot ahead of the evaluation
         pos_ff <= pos_next;
         eval_pos_ff <= pos_ff;
         rvalid_ff <= 1'b1;
         if (rvalid_ff) begin
            n_ff <= n_ff + 1'b1;
            if (rd_data.tag == TAG_TOMB && !saw_tomb_ff) begin
               saw_tomb_ff <= 1'b1;
               tomb_ff <= eval_pos_ff;
            end
            if (hit_now || empty_now) begin
               match_ff <= hit_now;
               empty_ff <= empty_now;
               hit_ff <= eval_pos_ff;
               count_ff <= n_ff;
            end else if (last_now) begin
               hit_ff <= eval_pos_ff;
               count_ff <= CNT_W'(SLOTS);
            end
         end
      end
      if (state_ff == S_FINISH) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff <= rsp_found_in;
         rsp_probes_ff <= skip_ff ? '0 : count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_probes = rsp_probes_ff;
   assign rsp_occupancy = occupancy;

endmodule

>>> verif/tb_linear_probe_hash_set.sv
// Self-checking bench for linear_probe_hash_set: directed rows, random traffic, fill-to-full
// and tombstone sweeps, then more random add/remove/query traffic against a local model.
// Depends on lph_pkg and the linear_probe_hash_set RTL only.
module tb_linear_probe_hash_set;
   import lph_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 256;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int POOL = 32;
   localparam int LIMIT = 1_500_000;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef struct packed {
      logic [1:0]       status;
      logic             found;
      logic [CNT_W-1:0] probes;
      logic [CNT_W-1:0] occupancy;
      logic [CNT_W-1:0] max_probes;
      logic [OPS_W-1:0] ops_done;
      logic [SUM_W-1:0] probe_total;
   } set_rsp_type;

   typedef struct {
      logic [1:0]        op;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hash;
      bit                pinned;
      set_rsp_type       rsp;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_operation = OP_IGNORE;
   logic [KEY_W-1:0] req_key_value = '0;
   logic [HASH_W-1:0] req_hash_value = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic rsp_found;
   logic [CNT_W-1:0] rsp_probes, rsp_occupancy, rsp_max_probes_seen;
   logic [OPS_W-1:0] rsp_operations_done;
   logic [SUM_W-1:0] rsp_probes_total;

   // typed-in expectation travels with the beat it belongs to
   bit pin_valid = 1'b0;
   set_rsp_type pin_rsp = '0;

   // local copy of the table and counters
   tag_type tag_mirror[SLOTS];
   logic [KEY_W-1:0] key_mirror[SLOTS];
   int live_mirror, worst_mirror;
   logic [OPS_W-1:0] ops_mirror;
   logic [SUM_W-1:0] sum_mirror;

   set_rsp_type pending_rsp[$];
   int errors = 0;
   int checked = 0;
   int full_adds = 0;
   int op_tally[4] = '{0, 0, 0, 0};
   int cycles = 0;
   bit gaps_on = 1'b1;

   logic [KEY_W-1:0] pool_key[POOL];
   logic [7:0] pool_slot[POOL];

   linear_probe_hash_set #(.SLOTS(SLOTS)) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_key_value(req_key_value),
      .req_hash_value(req_hash_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_found(rsp_found),
      .rsp_probes(rsp_probes),
      .rsp_occupancy(rsp_occupancy),
      .rsp_max_probes_seen(rsp_max_probes_seen),
      .rsp_operations_done(rsp_operations_done),
      .rsp_probes_total(rsp_probes_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic predict_set_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                 input logic [HASH_W-1:0] hash, output set_rsp_type r);
      int pos, n, tomb, dst;
      bit matched, at_empty, saw_tomb;
      r = '0;
      n = 0;
      tomb = 0;
      matched = 1'b0;
      at_empty = 1'b0;
      saw_tomb = 1'b0;
      pos = int'(hash % SLOTS);
      if (op == OP_ADD && live_mirror >= SLOTS) begin
         // full table: no walk, counters untouched
         r.status = ST_OVERFLOW;
      end else if (op != OP_IGNORE) begin
         while (n < SLOTS && !matched && !at_empty) begin
            if (tag_mirror[pos] == TAG_LIVE && key_mirror[pos] == key) begin
               matched = 1'b1;
            end else if (tag_mirror[pos] == TAG_EMPTY) begin
               at_empty = 1'b1;
            end else begin
               if (tag_mirror[pos] == TAG_TOMB && !saw_tomb) begin
                  saw_tomb = 1'b1;
                  tomb = pos;
               end
               pos = (pos + 1) % SLOTS;
               n++;
            end
         end
         if (n > worst_mirror) worst_mirror = n;
         if (ops_mirror != {OPS_W{1'b1}}) ops_mirror++;
         if (sum_mirror > SUM_MAX - SUM_W'(n)) sum_mirror = SUM_MAX;
         else sum_mirror = sum_mirror + SUM_W'(n);
         r.probes = CNT_W'(n);
         r.found = matched;
         if (op == OP_ADD) begin
            if (matched) begin
               r.status = ST_EXISTS;
            end else if (saw_tomb || at_empty) begin
               dst = saw_tomb ? tomb : pos;
               tag_mirror[dst] = TAG_LIVE;
               key_mirror[dst] = key;
               live_mirror++;
            end else begin
               r.status = ST_OVERFLOW;
            end
         end else if (matched) begin
            if (op == OP_REMOVE) begin
               tag_mirror[pos] = TAG_TOMB;
               if (live_mirror > 0) live_mirror--;
            end
         end else begin
            r.status = ST_NOT_FOUND;
         end
      end
      r.occupancy = CNT_W'(live_mirror);
      r.max_probes = CNT_W'(worst_mirror);
      r.ops_done = ops_mirror;
      r.probe_total = sum_mirror;
   endtask

   task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                              input logic [SUM_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // response side first, so a stray beat is never paired with a same-edge request
   always @(posedge clock) begin
      set_rsp_type got, want, predicted;
      cycles++;
      if (cycles > LIMIT) begin
         $display("%0t ns: timeout after %0d cycles", $time, cycles);
         $display("FAIL linear_probe_hash_set");
         $finish;
      end else begin
         if (rsp_valid) begin
            got = {rsp_status, rsp_found, rsp_probes, rsp_occupancy, rsp_max_probes_seen,
                   rsp_operations_done, rsp_probes_total};
            if (pending_rsp.size() == 0) begin
               errors++;
               $display("%0t ns: response beat with nothing expected, actual %0h",
                        $time, got);
            end else begin
               want = pending_rsp.pop_front();
               checked++;
               check_field("status", SUM_W'(want.status), SUM_W'(got.status));
               check_field("found", SUM_W'(want.found), SUM_W'(got.found));
               check_field("probes", SUM_W'(want.probes), SUM_W'(got.probes));
               check_field("occupancy", SUM_W'(want.occupancy), SUM_W'(got.occupancy));
               check_field("max_probes_seen", SUM_W'(want.max_probes),
                           SUM_W'(got.max_probes));
               check_field("operations_done", SUM_W'(want.ops_done), SUM_W'(got.ops_done));
               check_field("probes_total", want.probe_total, got.probe_total);
            end
         end
         if (!reset && start && !busy) begin
            predict_set_op(req_operation, req_key_value, req_hash_value, predicted);
            if (req_operation == OP_ADD && predicted.status == ST_OVERFLOW) full_adds++;
            op_tally[req_operation]++;
            pending_rsp.push_back(pin_valid ? pin_rsp : predicted);
         end
      end
   end

   // drive one beat and return at the edge that accepts it, start still high
   task automatic send(input logic [1:0] op, input logic [KEY_W-1:0] key,
                       input logic [HASH_W-1:0] hash, input bit pin = 1'b0,
                       input set_rsp_type rsp = '0);
      req_operation <= op;
      req_key_value <= key;
      req_hash_value <= hash;
      pin_valid <= pin;
      pin_rsp <= rsp;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pace();
      int n;
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         n = $urandom_range(1, 3);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic plan_row_type mk_row(input logic [1:0] op,
                                           input logic [KEY_W-1:0] key,
                                           input logic [HASH_W-1:0] hash,
                                           input bit pin = 1'b0,
                                           input set_rsp_type rsp = '0);
      plan_row_type t;
      t.op = op;
      t.key = key;
      t.hash = hash;
      t.pinned = pin;
      t.rsp = rsp;
      return t;
   endfunction

   task automatic random_ops(input int count, input bit quiet_tail);
      int i, idx, r;
      logic [1:0] op;
      logic [KEY_W-1:0] key;
      logic [HASH_W-1:0] hash;
      for (i = 0; i < count; i++) begin
         if (i % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         if (quiet_tail && i >= count - 150) gaps_on = 1'b0;
         r = $urandom_range(0, 99);
         if (r < 8) begin
            op = 2'($urandom_range(0, 3));
            key = $urandom;
            hash = $urandom;
         end else begin
            idx = $urandom_range(0, POOL - 1);
            if ($urandom_range(0, 99) < 3) begin
               pool_key[idx] = $urandom;
               pool_slot[idx] = 8'($urandom_range(0, 255));
            end
            r = $urandom_range(0, 99);
            op = (r < 40) ? OP_ADD : (r < 65) ? OP_REMOVE : (r < 95) ? OP_QUERY : OP_IGNORE;
            key = pool_key[idx];
            hash = {24'($urandom), pool_slot[idx]};
         end
         send(op, key, hash);
         pace();
      end
   endtask

   initial begin
      plan_row_type plan[$];
      logic [KEY_W-1:0] snap_key[SLOTS];
      bit snap_live[SLOTS];
      logic [KEY_W-1:0] kept_key;
      int i;

      for (i = 0; i < SLOTS; i++) begin
         tag_mirror[i] = TAG_EMPTY;
         key_mirror[i] = '0;
      end
      live_mirror = 0;
      worst_mirror = 0;
      ops_mirror = '0;
      sum_mirror = '0;
      // keys cluster around the wrap point so probe chains cross slot 255
      for (i = 0; i < POOL; i++) begin
         pool_key[i] = $urandom;
         pool_slot[i] = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(250, 261))
                                                    : 8'($urandom_range(0, 255));
      end

      plan.push_back(mk_row(OP_QUERY, 32'h0, 32'h0, 1'b1,
                            {ST_NOT_FOUND, 1'b0, 9'd0, 9'd0, 9'd0, 32'd1, 48'd0}));
      plan.push_back(mk_row(OP_IGNORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                            {ST_OK, 1'b0, 9'd0, 9'd0, 9'd0, 32'd1, 48'd0}));
      plan.push_back(mk_row(OP_ADD, 32'h0, 32'h0, 1'b1,
                            {ST_OK, 1'b0, 9'd0, 9'd1, 9'd0, 32'd2, 48'd0}));
      plan.push_back(mk_row(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                            {ST_OK, 1'b0, 9'd0, 9'd2, 9'd0, 32'd3, 48'd0}));
      plan.push_back(mk_row(OP_ADD, 32'h0, 32'h0, 1'b1,
                            {ST_EXISTS, 1'b1, 9'd0, 9'd2, 9'd0, 32'd4, 48'd0}));
      plan.push_back(mk_row(OP_ADD, 32'h1, 32'h0));
      plan.push_back(mk_row(OP_ADD, 32'h2, 32'hFF));
      plan.push_back(mk_row(OP_REMOVE, 32'h0, 32'h0));
      plan.push_back(mk_row(OP_REMOVE, 32'h0, 32'h0));
      plan.push_back(mk_row(OP_ADD, 32'h3, 32'h100));
      plan.push_back(mk_row(OP_QUERY, 32'h2, 32'hFF));
      plan.push_back(mk_row(OP_QUERY, 32'h5555_5555, 32'hAAAA_AA00));
      plan.push_back(mk_row(OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA));
      plan.push_back(mk_row(OP_ADD, 32'hAAAA_AAAA, 32'h5555_5555));
      plan.push_back(mk_row(OP_QUERY, 32'hAAAA_AAAA, 32'h5555_5555));
      plan.push_back(mk_row(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      plan.push_back(mk_row(OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      plan.push_back(mk_row(OP_IGNORE, 32'h0, 32'h0));
      plan.push_back(mk_row(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      plan.push_back(mk_row(OP_REMOVE, 32'h1, 32'h8000_0000));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[j]) begin
         send(plan[j].op, plan[j].key, plan[j].hash, plan[j].pinned, plan[j].rsp);
         pace();
      end

      random_ops(350, 1'b0);

      // fill every free slot with fresh keys
      gaps_on = 1'b1;
      drain();
      while (live_mirror < SLOTS) begin
         send(OP_ADD, $urandom, $urandom);
         pace();
         drain();
      end

      // full table: add refused, absent lookups walk all slots
      kept_key = key_mirror[0];
      send(OP_ADD, $urandom, $urandom);
      send(OP_ADD, kept_key, 32'h0);
      send(OP_QUERY, $urandom, $urandom);
      send(OP_QUERY, kept_key, 32'h0);
      send(OP_IGNORE, $urandom, $urandom);
      kept_key = key_mirror[7];
      send(OP_REMOVE, kept_key, 32'h7);
      send(OP_ADD, $urandom, 32'h7);
      send(OP_ADD, $urandom, $urandom);
      drain();

      // turn every slot into a tombstone
      for (i = 0; i < SLOTS; i++) begin
         snap_key[i] = key_mirror[i];
         snap_live[i] = (tag_mirror[i] == TAG_LIVE);
      end
      for (i = 0; i < SLOTS; i++) begin
         if (snap_live[i]) begin
            send(OP_REMOVE, snap_key[i], {24'($urandom), 8'(i)});
            pace();
         end
      end
      kept_key = $urandom;
      send(OP_QUERY, kept_key, $urandom);
      send(OP_ADD, kept_key, $urandom);
      send(OP_QUERY, kept_key, $urandom);
      send(OP_REMOVE, kept_key, $urandom);

      random_ops(250, 1'b1);

      drain();
      repeat (SLOTS + 20) @(posedge clock);

      $display("covered %0d adds (%0d refused as full), %0d removes, %0d queries, %0d ignored",
               op_tally[OP_ADD], full_adds, op_tally[OP_REMOVE], op_tally[OP_QUERY],
               op_tally[OP_IGNORE]);
      $display("deepest walk %0d slots, %0d beats checked, %0d mismatches, %0d left over",
               worst_mirror, checked, errors, pending_rsp.size());
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("PASS linear_probe_hash_set");
      end else begin
         $display("FAIL linear_probe_hash_set");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/lph_pkg.sv
hdl/lph_mod_reduce.sv
hdl/lph_table.sv
hdl/lph_stats.sv
hdl/linear_probe_hash_set.sv
verif/tb_linear_probe_hash_set.sv
